[rtl/assert_macros.svh]
// Assertion macros shared by the circumcircle RTL.
// Depends on i_clk and i_rst_n being present in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define CC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define CC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/ccirc_pkg.sv]
// Types and fixed constants of the circumcircle unit.
// No dependencies.
package ccirc_pkg;

    localparam int OUT_W     = 24;
    localparam int DXW       = 27;        // center-to-point offset, signed
    localparam int CMAX      = 8388607;
    localparam int CMIN      = -8388608;
    localparam int RMAX      = 16777215;
    localparam int FAR_LIMIT = 33554432;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SAT       = 2'd2
    } t_status;

endpackage

[rtl/ccirc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; carries a side tag along with the valid bit.
module ccirc_div #(
    parameter int NW = 39,
    parameter int DW = 27,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [NW-1:0] r_vld;
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];

    for (genvar gk = 0; gk < NW; gk++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] nq_in;
        logic [TW-1:0] tag_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (gk == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign den_in = i_den;
            assign nq_in  = i_num;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_vld[gk-1];
            assign rem_in = r_rem[gk-1];
            assign den_in = r_den[gk-1];
            assign nq_in  = r_nq[gk-1];
            assign tag_in = r_tag[gk-1];
        end

        assign trial = {rem_in, nq_in[NW-1]};
        assign ge    = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else begin
                r_vld[gk] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gk] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_nq[gk]  <= {nq_in[NW-2:0], ge};
            r_den[gk] <= den_in;
            r_tag[gk] <= tag_in;
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_tag   = r_tag[NW-1];

endmodule

[rtl/ccirc_sqrt.sv]
// Pipelined integer floor square root, one root bit per stage.
// Depends on nothing; carries a side tag along with the valid bit.
module ccirc_sqrt #(
    parameter int RW = 27,
    parameter int TW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_val,
    input  logic [TW-1:0]   i_tag,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [TW-1:0]   o_tag
);

    localparam int VW = 2 * RW;

    logic [RW-1:0] r_vld;
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [VW-1:0] r_val  [RW];
    logic [TW-1:0] r_tag  [RW];

    for (genvar gk = 0; gk < RW; gk++) begin : g_stage
        logic          v_in;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [VW-1:0] val_in;
        logic [TW-1:0] tag_in;
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (gk == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = i_val;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign v_in    = r_vld[gk-1];
            assign rem_in  = r_rem[gk-1];
            assign root_in = r_root[gk-1];
            assign val_in  = r_val[gk-1];
            assign tag_in  = r_tag[gk-1];
        end

        assign cur   = {rem_in, val_in[VW-1:VW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else begin
                r_vld[gk] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gk]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
            r_root[gk] <= {root_in[RW-2:0], ge};
            r_val[gk]  <= {val_in[VW-3:0], 2'b00};
            r_tag[gk]  <= tag_in;
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule

[rtl/circumcircle_from_three_points_unit.sv]
// Circumcircle unit: each request taken on start yields one result on o_valid.
// Throughput one request per cycle; busy is always low, the pipeline never stalls.
// The pipeline holds a bit-per-stage divider (3*COORD_BITS+3 stages) and root (27 stages).
// Synchronous active-low reset clears all valid bits; in-flight requests are dropped.
// Depends on ccirc_pkg, ccirc_div, ccirc_sqrt and assert_macros.svh.
`include "assert_macros.svh"

module circumcircle_from_three_points_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [COORD_BITS-1:0]          i_point_a_x,
    input  logic [COORD_BITS-1:0]          i_point_a_y,
    input  logic [COORD_BITS-1:0]          i_point_b_x,
    input  logic [COORD_BITS-1:0]          i_point_b_y,
    input  logic [COORD_BITS-1:0]          i_point_c_x,
    input  logic [COORD_BITS-1:0]          i_point_c_y,
    output logic                           o_valid,
    output logic signed [ccirc_pkg::OUT_W-1:0] o_center_x,
    output logic signed [ccirc_pkg::OUT_W-1:0] o_center_y,
    output logic [ccirc_pkg::OUT_W-1:0]    o_radius,
    output ccirc_pkg::t_status             o_status
);
    import ccirc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SW  = 2*C + 1;     // sum of squares
    localparam int DFW = C + 1;       // coordinate difference, signed
    localparam int PW  = SW + 1 + DFW;// numerator partial product, signed
    localparam int DPW = 2 * DFW;     // determinant partial product, signed
    localparam int NXW = 3*C + 4;     // numerator, signed
    localparam int DTW = 2*C + 3;     // determinant, signed
    localparam int NW  = NXW - 1;     // numerator magnitude
    localparam int DW  = DTW;         // divisor 2|D|
    localparam int OXW = NW + 1;      // signed quotient
    localparam int XTW = 2*C + 2;     // x-lane tag
    localparam int STW = 2*OUT_W + 3; // root tag
    localparam int LAT = 3*C + 39;

    // No backpressure anywhere: a request is taken every cycle.
    assign busy = 1'b0;

    // ---- stage 1: squares and coordinate differences
    logic              n_acc;
    logic              r1_v;
    logic [SW-1:0]     r1_sa, r1_sb, r1_sc;
    logic signed [DFW-1:0] r1_dy_cb, r1_dy_ac, r1_dy_ba;
    logic signed [DFW-1:0] r1_dx_bc, r1_dx_ca, r1_dx_ab;
    logic [C-1:0]      r1_ax, r1_ay;

    assign n_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sa    <= SW'(i_point_a_x) * SW'(i_point_a_x) + SW'(i_point_a_y) * SW'(i_point_a_y);
        r1_sb    <= SW'(i_point_b_x) * SW'(i_point_b_x) + SW'(i_point_b_y) * SW'(i_point_b_y);
        r1_sc    <= SW'(i_point_c_x) * SW'(i_point_c_x) + SW'(i_point_c_y) * SW'(i_point_c_y);
        r1_dy_cb <= $signed({1'b0, i_point_c_y}) - $signed({1'b0, i_point_b_y});
        r1_dy_ac <= $signed({1'b0, i_point_a_y}) - $signed({1'b0, i_point_c_y});
        r1_dy_ba <= $signed({1'b0, i_point_b_y}) - $signed({1'b0, i_point_a_y});
        r1_dx_bc <= $signed({1'b0, i_point_b_x}) - $signed({1'b0, i_point_c_x});
        r1_dx_ca <= $signed({1'b0, i_point_c_x}) - $signed({1'b0, i_point_a_x});
        r1_dx_ab <= $signed({1'b0, i_point_a_x}) - $signed({1'b0, i_point_b_x});
        r1_ax    <= i_point_a_x;
        r1_ay    <= i_point_a_y;
    end

    // ---- stage 2: one multiply per term
    // D = (bx-ax)(cy-ay) - (by-ay)(cx-ax) = (ax-bx)(ay-cy) - (by-ay)(cx-ax)
    logic              r2_v;
    logic signed [PW-1:0]  r2_px0, r2_px1, r2_px2, r2_py0, r2_py1, r2_py2;
    logic signed [DPW-1:0] r2_d0, r2_d1;
    logic [C-1:0]      r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_px0 <= $signed({1'b0, r1_sa}) * r1_dy_cb;
        r2_px1 <= $signed({1'b0, r1_sb}) * r1_dy_ac;
        r2_px2 <= $signed({1'b0, r1_sc}) * r1_dy_ba;
        r2_py0 <= $signed({1'b0, r1_sa}) * r1_dx_bc;
        r2_py1 <= $signed({1'b0, r1_sb}) * r1_dx_ca;
        r2_py2 <= $signed({1'b0, r1_sc}) * r1_dx_ab;
        r2_d0  <= r1_dx_ab * r1_dy_ac;
        r2_d1  <= r1_dy_ba * r1_dx_ca;
        r2_ax  <= r1_ax;
        r2_ay  <= r1_ay;
    end

    // ---- stage 3: sums
    logic              r3_v;
    logic signed [NXW-1:0] r3_nx, r3_ny;
    logic signed [DTW-1:0] r3_d;
    logic [C-1:0]      r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_nx <= NXW'(r2_px0) + NXW'(r2_px1) + NXW'(r2_px2);
        r3_ny <= NXW'(r2_py0) + NXW'(r2_py1) + NXW'(r2_py2);
        r3_d  <= DTW'(r2_d0) - DTW'(r2_d1);
        r3_ax <= r2_ax;
        r3_ay <= r2_ay;
    end

    // ---- stage 4: sign-magnitude split for the dividers
    // center = -N / (2D): negative when N and D share a sign.
    logic signed [NXW-1:0] n4_nxa, n4_nya;
    logic signed [DTW-1:0] n4_da;
    logic              r4_v;
    logic [NW-1:0]     r4_numx, r4_numy;
    logic [DW-1:0]     r4_den;
    logic              r4_negx, r4_negy, r4_zero;
    logic [C-1:0]      r4_ax, r4_ay;

    assign n4_nxa = r3_nx[NXW-1] ? -r3_nx : r3_nx;
    assign n4_nya = r3_ny[NXW-1] ? -r3_ny : r3_ny;
    assign n4_da  = r3_d[DTW-1]  ? -r3_d  : r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_numx <= n4_nxa[NW-1:0];
        r4_numy <= n4_nya[NW-1:0];
        r4_den  <= {n4_da[DW-2:0], 1'b0};
        r4_negx <= ~(r3_nx[NXW-1] ^ r3_d[DTW-1]);
        r4_negy <= ~(r3_ny[NXW-1] ^ r3_d[DTW-1]);
        r4_zero <= (r3_d == '0);
        r4_ax   <= r3_ax;
        r4_ay   <= r3_ay;
    end

    // ---- dividers, one per axis; collinear requests divide by zero and are masked later
    logic              w_vx, w_vy;
    logic [NW-1:0]     w_qx, w_qy;
    logic [XTW-1:0]    w_tagx;
    logic              w_tagy;

    ccirc_div #(.NW(NW), .DW(DW), .TW(XTW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_numx),
        .i_den   (r4_den),
        .i_tag   ({r4_negx, r4_zero, r4_ax, r4_ay}),
        .o_valid (w_vx),
        .o_quo   (w_qx),
        .o_tag   (w_tagx)
    );

    ccirc_div #(.NW(NW), .DW(DW), .TW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_numy),
        .i_den   (r4_den),
        .i_tag   (r4_negy),
        .o_valid (w_vy),
        .o_quo   (w_qy),
        .o_tag   (w_tagy)
    );

    // ---- stage 5: signed centers and far check
    logic              r5_v;
    logic signed [OXW-1:0] r5_ox, r5_oy;
    logic              r5_far, r5_zero;
    logic [C-1:0]      r5_ax, r5_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= w_vx;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ox   <= w_tagx[XTW-1] ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
        r5_oy   <= w_tagy        ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
        r5_far  <= (w_qx > NW'(FAR_LIMIT)) || (w_qy > NW'(FAR_LIMIT));
        r5_zero <= w_tagx[XTW-2];
        r5_ax   <= w_tagx[2*C-1:C];
        r5_ay   <= w_tagx[C-1:0];
    end

    // ---- stage 6: clamp centers, offsets to point A
    logic signed [OUT_W-1:0] n6_ex, n6_ey;
    logic              n6_satc;
    logic              r6_v;
    logic signed [OUT_W-1:0] r6_ex, r6_ey;
    logic signed [DXW-1:0] r6_dx, r6_dy;
    logic              r6_satc, r6_far, r6_zero;

    always_comb begin
        n6_satc = 1'b0;
        if (r5_ox > $signed(OXW'(CMAX))) begin
            n6_ex   = OUT_W'(CMAX);
            n6_satc = 1'b1;
        end else if (r5_ox < $signed(OXW'(CMIN))) begin
            n6_ex   = OUT_W'(CMIN);
            n6_satc = 1'b1;
        end else begin
            n6_ex   = r5_ox[OUT_W-1:0];
        end
        if (r5_oy > $signed(OXW'(CMAX))) begin
            n6_ey   = OUT_W'(CMAX);
            n6_satc = 1'b1;
        end else if (r5_oy < $signed(OXW'(CMIN))) begin
            n6_ey   = OUT_W'(CMIN);
            n6_satc = 1'b1;
        end else begin
            n6_ey   = r5_oy[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
    end

    // offsets only matter when the center is near, so 27 bits hold them
    always_ff @(posedge i_clk) begin
        r6_ex   <= n6_ex;
        r6_ey   <= n6_ey;
        r6_dx   <= DXW'(r5_ox - $signed(OXW'(r5_ax)));
        r6_dy   <= DXW'(r5_oy - $signed(OXW'(r5_ay)));
        r6_satc <= n6_satc;
        r6_far  <= r5_far;
        r6_zero <= r5_zero;
    end

    // ---- stage 7: squares
    logic              r7_v;
    logic signed [2*DXW-1:0] r7_sqx, r7_sqy;
    logic [STW-1:0]    r7_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_sqx <= r6_dx * r6_dx;
        r7_sqy <= r6_dy * r6_dy;
        r7_tag <= {r6_ex, r6_ey, r6_satc, r6_far, r6_zero};
    end

    // ---- stage 8: squared distance
    logic              r8_v;
    logic [2*DXW-1:0]  r8_dist;
    logic [STW-1:0]    r8_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_dist <= $unsigned(r7_sqx) + $unsigned(r7_sqy);
        r8_tag  <= r7_tag;
    end

    // ---- floor square root
    logic              w_vs;
    logic [DXW-1:0]    w_root;
    logic [STW-1:0]    w_tags;

    ccirc_sqrt #(.RW(DXW), .TW(STW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r8_v),
        .i_val   (r8_dist),
        .i_tag   (r8_tag),
        .o_valid (w_vs),
        .o_root  (w_root),
        .o_tag   (w_tags)
    );

    // ---- output register: radius clamp, status, collinear override
    logic              n_big, n_far, n_zero, n_satc;
    logic [OUT_W-1:0]  n_rad;
    logic              r_valid;
    logic signed [OUT_W-1:0] r_cx, r_cy;
    logic [OUT_W-1:0]  r_rad;
    t_status           r_status;

    assign n_zero = w_tags[0];
    assign n_far  = w_tags[1];
    assign n_satc = w_tags[2];
    assign n_big  = (w_root > DXW'(RMAX));
    assign n_rad  = (n_far || n_big) ? OUT_W'(RMAX) : w_root[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_zero) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_rad    <= '0;
            r_status <= ST_COLLINEAR;
        end else begin
            r_cx     <= w_tags[STW-1:STW-OUT_W];
            r_cy     <= w_tags[STW-OUT_W-1:3];
            r_rad    <= n_rad;
            r_status <= (n_satc || n_far || n_big) ? ST_SAT : ST_OK;
        end
    end

    assign o_valid    = r_valid;
    assign o_center_x = r_cx;
    assign o_center_y = r_cy;
    assign o_radius   = r_rad;
    assign o_status   = r_status;

    // result qualifiers for the checks below
    logic              w_col_out, w_zero_out, w_ok_out;

    assign w_col_out  = o_valid && (o_status == ST_COLLINEAR);
    assign w_zero_out = (o_radius == '0) && (o_center_x == '0) && (o_center_y == '0);
    assign w_ok_out   = o_valid && (o_status == ST_OK);

    `CC_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `CC_ASSERT(a_lanes_aligned, w_vx == w_vy, "divider lanes out of step")
    `CC_ASSERT(a_latency, o_valid |-> $past(start, LAT), "result without a request")
    `CC_ASSERT(a_collinear_zero, w_col_out |-> w_zero_out, "collinear result not zeroed")
    `CC_ASSERT(a_sat_radius, w_ok_out |-> !$past(n_big), "clamped radius reported ok")

endmodule
